FILE: sv/lidar_point_filter_transform_defines.svh
// ----------------------------------------------------------------------------
// lidar_point_filter_transform_defines
// Assertion macros shared by the lidar point filter RTL.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_FILTER_TRANSFORM_DEFINES_SVH
`define LIDAR_POINT_FILTER_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPFT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lpft assertion failed");

// Next-cycle implication, disabled during reset.
`define LPFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lpft assertion failed");

`endif

FILE: sv/lpft_pkg.sv
// ----------------------------------------------------------------------------
// lpft_pkg
// Types, widths and register codes for the lidar point filter and transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpft_pkg;

    localparam int POS_W    = 19;   // input coordinate, signed mm
    localparam int OUT_W    = 21;   // output coordinate, signed mm
    localparam int ROT_W    = 16;   // rotation matrix entry
    localparam int TRANS_W  = 20;   // translation entry, signed mm
    localparam int RANGE_W  = 36;   // squared range limits
    localparam int OFS_W    = 32;   // point offset, ns
    localparam int BASE_W   = 63;   // time bases, ns
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 4;
    localparam int CFG_W    = 64;
    localparam int S_TDATA_W = 240;
    localparam int M_TDATA_W = 120;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_ROT_ROW0   = 4'd0;
    localparam logic [IDX_W-1:0] REG_ROT_ROW1   = 4'd1;
    localparam logic [IDX_W-1:0] REG_ROT_ROW2   = 4'd2;
    localparam logic [IDX_W-1:0] REG_TRANSLATION = 4'd3;
    localparam logic [IDX_W-1:0] REG_XFORM_READY = 4'd4;
    localparam logic [IDX_W-1:0] REG_PRI_MIN_SQ  = 4'd5;
    localparam logic [IDX_W-1:0] REG_SEC_MIN_SQ  = 4'd6;
    localparam logic [IDX_W-1:0] REG_MAX_SQ      = 4'd7;

    localparam logic [3*ROT_W-1:0]   RST_ROT_ROW0 = 48'd268435456;
    localparam logic [3*ROT_W-1:0]   RST_ROT_ROW1 = 48'd16384;
    localparam logic [3*ROT_W-1:0]   RST_ROT_ROW2 = 48'd16384;
    localparam logic [3*TRANS_W-1:0] RST_TRANSLATION = 60'd0;
    localparam logic [RANGE_W-1:0]   RST_PRI_MIN_SQ = 36'd100000;
    localparam logic [RANGE_W-1:0]   RST_SEC_MIN_SQ = 36'd250000;
    localparam logic [RANGE_W-1:0]   RST_MAX_SQ     = 36'd10000000000;

    // Source encoding
    localparam logic SRC_PRIMARY   = 1'b0;
    localparam logic SRC_SECONDARY = 1'b1;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [OUT_W-1:0] coord_t;

    typedef struct packed {
        logic [3*ROT_W-1:0]   rot_row0;
        logic [3*ROT_W-1:0]   rot_row1;
        logic [3*ROT_W-1:0]   rot_row2;
        logic [3*TRANS_W-1:0] translation;
        logic                 xform_ready;
        logic [RANGE_W-1:0]   pri_min_sq;
        logic [RANGE_W-1:0]   sec_min_sq;
        logic [RANGE_W-1:0]   max_sq;
    } cfg_t;

    // Per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    // Qualification result of the stage 3 logic
    typedef struct packed {
        logic             keep;
        logic             src;
        logic [OFS_W-1:0] offset;
    } qual_t;

endpackage

FILE: sv/lidar_point_filter_transform.sv
// ----------------------------------------------------------------------------
// lidar_point_filter_transform
// Range filter and rigid transform of merged lidar points.
// ----------------------------------------------------------------------------
// Accepts one point per clock while s_tready is high and, when it is kept,
// presents its result beat after stage 1 multipliers, stage 2 sums and
// rebasing and stage 3 compare/saturate into the output register. Dropped
// points produce no output beat. Each stage holds its own valid bit and
// loads whenever it is empty or its successor moves on, so bubbles are
// squeezed out and input is still taken while a result waits on m_tready;
// s_tready falls only when all three stages are full and the output is
// stalled. Configuration writes are accepted every cycle (cfg_ready is
// tied high) and must only be issued while no point is in flight; indexes
// beyond seven are ignored.
`timescale 1ns / 1ps
`include "lidar_point_filter_transform_defines.svh"

module lidar_point_filter_transform #(
    parameter int unsigned TIME_WINDOW_NS = 120000000,
    parameter int unsigned ROT_FRAC_BITS  = 14
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pos_x[18:0] pos_y[37:19] pos_z[56:38] point_offset[88:57]
    // message_base[151:89] frame_base[214:152] reflectivity[222:215]
    // point_tag[230:223] scan_line[238:231] zero pad[239]
    input  logic [lpft_pkg::S_TDATA_W-1:0]   s_tdata,
    // source[0]
    input  logic [0:0]                       s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_x[20:0] out_y[41:21] out_z[62:42] out_offset[94:63]
    // out_reflectivity[102:95] out_tag[110:103] out_line[118:111] zero pad[119]
    output logic [lpft_pkg::M_TDATA_W-1:0]   m_tdata,
    // out_source[0]
    output logic [0:0]                       m_tuser,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lpft_pkg::IDX_W-1:0]       cfg_index,
    input  logic [lpft_pkg::CFG_W-1:0]       cfg_data
);
    import lpft_pkg::*;

    cfg_t                cfg_reg;
    pipe_en_t            en;

    logic                v1_reg;
    logic                v2_reg;
    logic                rdy1, rdy2, rdy3;

    pos_t                in_pos [3];
    logic [OFS_W-1:0]    in_offset;
    logic [BASE_W-1:0]   in_msg_base;
    logic [BASE_W-1:0]   in_frame_base;
    logic [3*BYTE_W-1:0] in_bytes;

    logic [3*BYTE_W-1:0] bytes1_reg;
    logic [3*BYTE_W-1:0] bytes2_reg;

    coord_t              coord [3];
    qual_t               qual;

    logic                m_valid_reg;
    logic                m_src_reg;
    coord_t              m_coord_reg [3];
    logic [OFS_W-1:0]    m_offset_reg;
    logic [3*BYTE_W-1:0] m_bytes_reg;

    // Input unpacking
    assign in_pos[0]     = s_tdata[18:0];
    assign in_pos[1]     = s_tdata[37:19];
    assign in_pos[2]     = s_tdata[56:38];
    assign in_offset     = s_tdata[88:57];
    assign in_msg_base   = s_tdata[151:89];
    assign in_frame_base = s_tdata[214:152];
    assign in_bytes      = s_tdata[238:215];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rot_row0    <= RST_ROT_ROW0;
            cfg_reg.rot_row1    <= RST_ROT_ROW1;
            cfg_reg.rot_row2    <= RST_ROT_ROW2;
            cfg_reg.translation <= RST_TRANSLATION;
            cfg_reg.xform_ready <= 1'b0;
            cfg_reg.pri_min_sq  <= RST_PRI_MIN_SQ;
            cfg_reg.sec_min_sq  <= RST_SEC_MIN_SQ;
            cfg_reg.max_sq      <= RST_MAX_SQ;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ROT_ROW0:    cfg_reg.rot_row0    <= cfg_data[3*ROT_W-1:0];
                REG_ROT_ROW1:    cfg_reg.rot_row1    <= cfg_data[3*ROT_W-1:0];
                REG_ROT_ROW2:    cfg_reg.rot_row2    <= cfg_data[3*ROT_W-1:0];
                REG_TRANSLATION: cfg_reg.translation <= cfg_data[3*TRANS_W-1:0];
                REG_XFORM_READY: cfg_reg.xform_ready <= cfg_data[0];
                REG_PRI_MIN_SQ:  cfg_reg.pri_min_sq  <= cfg_data[RANGE_W-1:0];
                REG_SEC_MIN_SQ:  cfg_reg.sec_min_sq  <= cfg_data[RANGE_W-1:0];
                REG_MAX_SQ:      cfg_reg.max_sq      <= cfg_data[RANGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Per-stage flow control: a stage loads when empty or draining
    assign rdy3 = !m_valid_reg || m_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1    = rdy1;
    assign en.s2    = rdy2;
    assign en.s3    = rdy3;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en.s1) begin
                v1_reg <= s_tvalid;
            end
            if (en.s2) begin
                v2_reg <= v1_reg;
            end
            if (en.s3) begin
                m_valid_reg <= v2_reg && qual.keep;
            end
        end
    end

    // Pass-through bytes ride alongside the datapath
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            bytes1_reg <= in_bytes;
        end
        if (en.s2) begin
            bytes2_reg <= bytes1_reg;
        end
    end

    lpft_xform #(
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_xform (
        .aclk  (aclk),
        .en    (en),
        .cfg   (cfg_reg),
        .src   (s_tuser[0]),
        .pos   (in_pos),
        .coord (coord)
    );

    lpft_qual #(
        .TIME_WINDOW_NS (TIME_WINDOW_NS)
    ) u_qual (
        .aclk         (aclk),
        .en           (en),
        .cfg          (cfg_reg),
        .src          (s_tuser[0]),
        .pos          (in_pos),
        .point_offset (in_offset),
        .message_base (in_msg_base),
        .frame_base   (in_frame_base),
        .qual         (qual)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (en.s3) begin
            m_src_reg    <= qual.src;
            m_offset_reg <= qual.offset;
            m_bytes_reg  <= bytes2_reg;
            for (int i = 0; i < 3; i++) begin
                m_coord_reg[i] <= coord[i];
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = m_src_reg;
    assign m_tdata    = {1'b0, m_bytes_reg, m_offset_reg,
                         m_coord_reg[2], m_coord_reg[1], m_coord_reg[0]};

    // Full pipeline with a stalled output must refuse new points
    `LPFT_ASSERT_NOW(a_full_stall, aclk, aresetn, v1_reg && v2_reg && m_valid_reg && !m_tready, !s_tready)
    // An accepted beat always occupies stage 1 next cycle
    `LPFT_ASSERT_NEXT(a_accept_s1, aclk, aresetn, s_tvalid && s_tready, v1_reg)
    // No result appears without a point in stage 2
    `LPFT_ASSERT_NEXT(a_no_phantom, aclk, aresetn, !m_valid_reg && !v2_reg, !m_valid_reg)
    // Secondary results stay inside the time window
    `LPFT_ASSERT_NOW(a_window, aclk, aresetn, m_valid_reg && (m_src_reg == SRC_SECONDARY), m_offset_reg <= OFS_W'(TIME_WINDOW_NS))

endmodule

FILE: sv/lpft_xform.sv
// ----------------------------------------------------------------------------
// lpft_xform
// Coordinate path: rotation products, row sums plus translation, then floor
// shift and saturation. Primary points bypass the transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpft_xform #(
    parameter int unsigned ROT_FRAC_BITS = 14
) (
    input  logic                aclk,
    input  lpft_pkg::pipe_en_t  en,
    input  lpft_pkg::cfg_t      cfg,
    input  logic                src,
    input  lpft_pkg::pos_t      pos [3],
    output lpft_pkg::coord_t    coord [3]
);
    import lpft_pkg::*;

    localparam int PROD_W = ROT_W + POS_W;
    localparam int T_SH_W = TRANS_W + int'(ROT_FRAC_BITS);
    localparam int ACC_W  = ((T_SH_W > PROD_W) ? T_SH_W : PROD_W) + 2;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (OUT_W - 1)));

    logic signed [ROT_W-1:0]   rot   [3][3];
    logic signed [TRANS_W-1:0] trans [3];

    logic signed [PROD_W-1:0]  prod_reg [3][3];
    pos_t                      pos1_reg [3];
    logic                      src1_reg;

    logic signed [ACC_W-1:0]   acc_next [3];
    logic signed [ACC_W-1:0]   acc_reg  [3];
    pos_t                      pos2_reg [3];
    logic                      src2_reg;

    // Entry zero sits in the top bits of each packed word
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            rot[0][j] = cfg.rot_row0[(3-j)*ROT_W-1 -: ROT_W];
            rot[1][j] = cfg.rot_row1[(3-j)*ROT_W-1 -: ROT_W];
            rot[2][j] = cfg.rot_row2[(3-j)*ROT_W-1 -: ROT_W];
            trans[j]  = cfg.translation[(3-j)*TRANS_W-1 -: TRANS_W];
        end
    end

    // Stage 1: nine products
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= PROD_W'(rot[i][j]) * PROD_W'(pos[j]);
                end
                pos1_reg[i] <= pos[i];
            end
            src1_reg <= src;
        end
    end

    // Stage 2: row sums with translation scaled to the matrix fraction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_next[i] = ACC_W'(prod_reg[i][0]) + ACC_W'(prod_reg[i][1])
                        + ACC_W'(prod_reg[i][2])
                        + (ACC_W'(trans[i]) <<< ROT_FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i]  <= acc_next[i];
                pos2_reg[i] <= pos1_reg[i];
            end
            src2_reg <= src1_reg;
        end
    end

    // Stage 3 logic: arithmetic shift is a floor division
    always_comb begin
        logic signed [ACC_W-1:0] shifted;
        for (int i = 0; i < 3; i++) begin
            shifted = acc_reg[i] >>> ROT_FRAC_BITS;
            if (src2_reg == SRC_PRIMARY) begin
                coord[i] = OUT_W'(pos2_reg[i]);
            end else if (shifted > SAT_HI) begin
                coord[i] = SAT_HI[OUT_W-1:0];
            end else if (shifted < SAT_LO) begin
                coord[i] = SAT_LO[OUT_W-1:0];
            end else begin
                coord[i] = shifted[OUT_W-1:0];
            end
        end
    end

endmodule

FILE: sv/lpft_qual.sv
// ----------------------------------------------------------------------------
// lpft_qual
// Keep/drop path: squared range, secondary time rebasing and window check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpft_qual #(
    parameter int unsigned TIME_WINDOW_NS = 120000000
) (
    input  logic                          aclk,
    input  lpft_pkg::pipe_en_t            en,
    input  lpft_pkg::cfg_t                cfg,
    input  logic                          src,
    input  lpft_pkg::pos_t                pos [3],
    input  logic [lpft_pkg::OFS_W-1:0]    point_offset,
    input  logic [lpft_pkg::BASE_W-1:0]   message_base,
    input  logic [lpft_pkg::BASE_W-1:0]   frame_base,
    output lpft_pkg::qual_t               qual
);
    import lpft_pkg::*;

    localparam int SQ_W   = 2 * POS_W - 1;   // one square, always non-negative
    localparam int R2_W   = SQ_W + 1;        // sum of three
    localparam int ABS_W  = BASE_W + 1;
    localparam logic [ABS_W-1:0] WINDOW = ABS_W'(TIME_WINDOW_NS);

    logic signed [2*POS_W-1:0] sq_full [3];
    logic [SQ_W-1:0]           sq_reg  [3];
    logic [ABS_W-1:0]          abs_reg;
    logic [BASE_W-1:0]         fbase1_reg;
    logic [OFS_W-1:0]          ofs1_reg;
    logic                      src1_reg;

    logic [ABS_W:0]            diff;
    logic [R2_W-1:0]           r2_reg;
    logic                      early_reg;
    logic [ABS_W-1:0]          delta_reg;
    logic [OFS_W-1:0]          ofs2_reg;
    logic                      src2_reg;

    logic                      late;
    logic                      range_ok;
    logic [RANGE_W-1:0]        min_sq;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sq_full[j] = (2*POS_W)'(pos[j]) * (2*POS_W)'(pos[j]);
        end
    end

    // Stage 1: squares and absolute point time
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            for (int j = 0; j < 3; j++) begin
                sq_reg[j] <= sq_full[j][SQ_W-1:0];
            end
            abs_reg    <= {1'b0, message_base} + ABS_W'(point_offset);
            fbase1_reg <= frame_base;
            ofs1_reg   <= point_offset;
            src1_reg   <= src;
        end
    end

    // Stage 2: range sum and rebasing; the extra top bit flags a point
    // earlier than the frame base
    assign diff = {1'b0, abs_reg} - {2'b00, fbase1_reg};

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            r2_reg    <= R2_W'(sq_reg[0]) + R2_W'(sq_reg[1]) + R2_W'(sq_reg[2]);
            early_reg <= diff[ABS_W];
            delta_reg <= diff[ABS_W-1:0];
            ofs2_reg  <= ofs1_reg;
            src2_reg  <= src1_reg;
        end
    end

    // Stage 3 logic: limits are inclusive
    assign min_sq   = (src2_reg == SRC_SECONDARY) ? cfg.sec_min_sq : cfg.pri_min_sq;
    assign range_ok = (r2_reg >= R2_W'(min_sq)) && (r2_reg <= R2_W'(cfg.max_sq));
    assign late     = delta_reg > WINDOW;

    always_comb begin
        qual.src = src2_reg;
        if (src2_reg == SRC_SECONDARY) begin
            qual.keep   = cfg.xform_ready && !early_reg && !late && range_ok;
            qual.offset = delta_reg[OFS_W-1:0];
        end else begin
            qual.keep   = range_ok;
            qual.offset = ofs2_reg;
        end
    end

endmodule
